[hdl/rrdl_pkg.sv]
// Shared types and constants for the resampling reference delay line.
// No dependencies; used by the front end, the back end and the top of the block.
package rrdl_pkg;

    localparam int RING_DEPTH_DEF = 16384;
    localparam int SPM_DEF        = 16;
    localparam int GAP_SLACK_MS   = 20;
    localparam int FRAME_MAX      = 1024;
    localparam int CNT_W          = 17;
    localparam int CFG_W          = 11;
    localparam int SAMPLE_W       = 16;

    localparam logic [9:0]  DELAY_RST = 10'd320;
    localparam logic [10:0] FRAME_RST = 11'd512;

    localparam logic CFG_IDX_DELAY = 1'b0;
    localparam logic CFG_IDX_FRAME = 1'b1;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_GAP   = 2'd1,
        CMD_FETCH = 2'd2,
        CMD_FLUSH = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                       cmd;
        logic signed [SAMPLE_W-1:0] sample;
        logic [CNT_W-1:0]           zeros;
        logic [9:0]                 offset;
    } t_op;

endpackage

[hdl/rrdl_in_if.sv]
// Input channel of the delay line: valid/ready plus command payload.
// Depends on nothing.
interface rrdl_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [15:0] spk_sample;
    logic [15:0]        gap_ms;
    logic [15:0]        block_ms;
    logic [9:0]         frame_offset;

    modport source (output valid, cmd, spk_sample, gap_ms, block_ms, frame_offset,
                    input ready);
    modport sink   (input valid, cmd, spk_sample, gap_ms, block_ms, frame_offset,
                    output ready);
endinterface

[hdl/rrdl_out_if.sv]
// Result channel of the delay line: valid/ready plus fetched sample.
// Depends on nothing.
interface rrdl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] ref_sample;
    logic               primed;

    modport source (output valid, ref_sample, primed, input ready);
    modport sink   (input valid, ref_sample, primed, output ready);
endinterface

[hdl/rrdl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrdl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hdl/rrdl_front.sv]
// Front end: accepts commands, precomputes gap fill length, queues ops.
// Depends on rrdl_pkg and rrdl_in_if.
module rrdl_front #(
    parameter int RING_DEPTH     = rrdl_pkg::RING_DEPTH_DEF,
    parameter int SAMPLES_PER_MS = rrdl_pkg::SPM_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_hold,
    rrdl_in_if.sink       i_in,
    output logic          o_q_valid,
    output rrdl_pkg::t_op o_q_op,
    input  logic          i_q_pop
);
    localparam int PW = 16 + $clog2(SAMPLES_PER_MS + 1);

    rrdl_pkg::t_op r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    logic                       big;
    logic [15:0]                diff;
    logic [PW-1:0]              prod;
    logic [rrdl_pkg::CNT_W-1:0] zeros;
    rrdl_pkg::t_op              op;
    logic                       push;

    always_comb begin
        big  = {1'b0, i_in.gap_ms} > ({1'b0, i_in.block_ms} + 17'(rrdl_pkg::GAP_SLACK_MS));
        diff = i_in.gap_ms - i_in.block_ms;
        prod = PW'(diff) * PW'(SAMPLES_PER_MS);
        if (!big) begin
            zeros = '0;
        end else if (prod > PW'(RING_DEPTH)) begin
            zeros = rrdl_pkg::CNT_W'(RING_DEPTH);
        end else begin
            zeros = prod[rrdl_pkg::CNT_W-1:0];
        end
        op.cmd    = rrdl_pkg::t_cmd'(i_in.cmd);
        op.sample = i_in.spk_sample;
        op.zeros  = zeros;
        op.offset = i_in.frame_offset;
    end

    assign i_in.ready = !i_hold && (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_op     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule

[hdl/rrdl_back.sv]
// Back end: prefilter, 3:2 interpolation, ring writes, gap fill, flush sweep, fetch.
// Depends on rrdl_pkg, rrdl_out_if and rrdl_ram.
module rrdl_back #(
    parameter int RING_DEPTH     = rrdl_pkg::RING_DEPTH_DEF,
    parameter int SAMPLES_PER_MS = rrdl_pkg::SPM_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [9:0]    i_delay_ms,
    input  logic [10:0]   i_frame_samples,
    input  logic          i_rearm,
    input  logic          i_q_valid,
    input  rrdl_pkg::t_op i_q_op,
    output logic          o_q_pop,
    output logic          o_init_busy,
    rrdl_out_if.source    o_out
);
    localparam int AW = $clog2(RING_DEPTH);
    localparam int DW = $clog2(1023 * SAMPLES_PER_MS + rrdl_pkg::FRAME_MAX + 2);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_GAP   = 4'b0100,
        S_READ  = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [AW-1:0]              r_clr;
    logic                       r_init;
    logic [rrdl_pkg::CNT_W-1:0] r_zcnt;
    logic [31:0]                r_wcnt;
    logic                       r_primed;
    logic signed [15:0]         r_h1, r_h2, r_lf;
    logic [1:0]                 r_phase;
    logic                       r_had;
    logic [10:0]                r_feff;
    logic [AW-1:0]              r_deff, r_thr;
    logic                       r_hit;
    logic                       r_ovalid;
    logic signed [15:0]         r_osample;
    logic                       r_oprimed;

    logic [10:0]        feff;
    logic [DW-1:0]      draw, dsum;
    logic [AW-1:0]      deff;
    logic               out_free;
    logic               pop;
    logic signed [17:0] fsum;
    logic signed [15:0] y;
    logic signed [16:0] msum;
    logic signed [15:0] half;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [15:0]        ram_wdata, ram_rdata;
    logic               wr_ring;
    logic [31:0]        wnext;
    logic               fetch_hit;

    always_comb begin
        if (i_frame_samples == 11'd0) begin
            feff = 11'd1;
        end else if (i_frame_samples > 11'(rrdl_pkg::FRAME_MAX)) begin
            feff = 11'(rrdl_pkg::FRAME_MAX);
        end else begin
            feff = i_frame_samples;
        end
        draw = DW'(i_delay_ms * SAMPLES_PER_MS);
        dsum = draw + DW'(feff);
        if (32'(dsum) >= RING_DEPTH) begin
            deff = AW'(RING_DEPTH - 1) - AW'(feff);
        end else begin
            deff = draw[AW-1:0];
        end
    end

    assign out_free  = !r_ovalid || o_out.ready;
    assign pop       = (r_state == S_IDLE) && i_q_valid &&
                       ((i_q_op.cmd != rrdl_pkg::CMD_FETCH) || out_free);
    assign o_q_pop   = pop;
    assign o_init_busy = r_init;

    always_comb begin
        fsum = 18'(r_h2) + (18'(r_h1) <<< 1) + 18'(i_q_op.sample);
        y    = 16'(fsum >>> 2);
        msum = 17'(r_lf) + 17'(y);
        half = 16'((msum + 17'(msum[16])) >>> 1);
    end

    always_comb begin
        wr_ring   = 1'b0;
        ram_wdata = '0;
        if (r_state == S_GAP) begin
            wr_ring = 1'b1;
        end else if (pop && (i_q_op.cmd == rrdl_pkg::CMD_PUSH)) begin
            unique case (r_phase)
                2'd0: begin
                    wr_ring   = 1'b1;
                    ram_wdata = r_lf;
                end
                2'd1: begin
                    wr_ring   = 1'b1;
                    ram_wdata = half;
                end
                default: wr_ring = 1'b0;
            endcase
        end
        ram_we    = wr_ring || (r_state == S_CLEAR);
        ram_waddr = (r_state == S_CLEAR) ? r_clr : r_wcnt[AW-1:0];
        ram_raddr = r_wcnt[AW-1:0] - r_deff - AW'(r_feff) + AW'(i_q_op.offset);
        wnext     = r_wcnt + 32'd1;
        fetch_hit = r_primed && ({1'b0, i_q_op.offset} < r_feff);
    end

    rrdl_ram #(.WIDTH(16), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(RING_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (pop) begin
                    unique case (i_q_op.cmd)
                        rrdl_pkg::CMD_FLUSH: n_state = S_CLEAR;
                        rrdl_pkg::CMD_FETCH: n_state = S_READ;
                        rrdl_pkg::CMD_GAP: begin
                            if (r_had && i_q_op.zeros != '0) n_state = S_GAP;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_GAP: begin
                if (r_zcnt == rrdl_pkg::CNT_W'(1)) n_state = S_IDLE;
            end
            S_READ:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_feff <= feff;
        r_deff <= deff;
        r_thr  <= deff + AW'(feff);
        if (r_state == S_GAP) begin
            r_zcnt <= r_zcnt - rrdl_pkg::CNT_W'(1);
        end else if (pop) begin
            r_zcnt <= i_q_op.zeros;
        end
        if (pop && i_q_op.cmd == rrdl_pkg::CMD_FETCH) begin
            r_hit     <= fetch_hit;
            r_oprimed <= r_primed;
        end
        if (r_state == S_READ) begin
            r_osample <= r_hit ? ram_rdata : 16'sd0;
        end
        if (!i_rst_n) begin
            r_h2 <= '0;
            r_h1 <= '0;
            r_lf <= '0;
        end else if (pop && i_q_op.cmd == rrdl_pkg::CMD_PUSH) begin
            r_h2 <= r_h1;
            r_h1 <= i_q_op.sample;
            r_lf <= y;
        end else if (pop && i_q_op.cmd == rrdl_pkg::CMD_FLUSH) begin
            r_h2 <= '0;
            r_h1 <= '0;
            r_lf <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_init   <= 1'b1;
            r_wcnt   <= '0;
            r_primed <= 1'b0;
            r_phase  <= 2'd0;
            r_had    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
                if (n_state == S_IDLE) r_init <= 1'b0;
            end else begin
                r_clr <= '0;
            end
            if (wr_ring) begin
                r_wcnt <= wnext;
            end
            if (i_rearm) begin
                r_primed <= 1'b0;
            end else if (wr_ring && wnext >= 32'(r_thr)) begin
                r_primed <= 1'b1;
            end
            if (pop && i_q_op.cmd == rrdl_pkg::CMD_PUSH) begin
                r_had <= 1'b1;
                unique case (r_phase)
                    2'd0:    r_phase <= 2'd1;
                    2'd1:    r_phase <= 2'd2;
                    2'd2:    r_phase <= 2'd0;
                    default: r_phase <= 2'd1;
                endcase
            end else if (pop && i_q_op.cmd == rrdl_pkg::CMD_FLUSH) begin
                r_had   <= 1'b0;
                r_phase <= 2'd0;
            end
            if (r_state == S_READ) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.ref_sample = r_osample;
    assign o_out.primed     = r_oprimed;

`ifndef SYNTH
    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> !r_ovalid)
        else $error("fetch result would overwrite a pending beat");
    a_primed_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_primed) |-> $past(i_rearm))
        else $error("primed cleared without a register write");
    a_wcnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcnt != $past(r_wcnt) |-> r_wcnt == 32'($past(r_wcnt) + 32'd1))
        else $error("write count jumped");
    a_gap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GAP |-> r_zcnt != '0)
        else $error("gap fill running with empty count");
`endif
endmodule

[hdl/resampling_reference_delay_line.sv]
// Push, gap and flush give no result beat; each accepted fetch gives exactly one beat.
// A gap fill writes its zero count to the ring; a flush sweeps all RING_DEPTH ring entries.
// Rate is set by the single write port of the ring RAM; a 2-deep queue decouples the input.
// Reset: synchronous, active low; a clearing pass over all RING_DEPTH entries then runs with input held off.
// Configuration writes are taken at any time and clear primed.
module resampling_reference_delay_line #(
    parameter int RING_DEPTH     = rrdl_pkg::RING_DEPTH_DEF,
    parameter int SAMPLES_PER_MS = rrdl_pkg::SPM_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [rrdl_pkg::CFG_W-1:0] i_cfg_data,
    rrdl_in_if.sink                    i_in,
    rrdl_out_if.source                 o_out
);
    logic [9:0]    r_delay_ms;
    logic [10:0]   r_frame_samples;
    logic          q_valid, q_pop, init_busy;
    rrdl_pkg::t_op q_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_ms      <= rrdl_pkg::DELAY_RST;
            r_frame_samples <= rrdl_pkg::FRAME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rrdl_pkg::CFG_IDX_DELAY: r_delay_ms      <= i_cfg_data[9:0];
                rrdl_pkg::CFG_IDX_FRAME: r_frame_samples <= i_cfg_data;
                default:                 r_delay_ms      <= r_delay_ms;
            endcase
        end
    end

    rrdl_front #(.RING_DEPTH(RING_DEPTH), .SAMPLES_PER_MS(SAMPLES_PER_MS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hold    (init_busy),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_op    (q_op),
        .i_q_pop   (q_pop)
    );

    rrdl_back #(.RING_DEPTH(RING_DEPTH), .SAMPLES_PER_MS(SAMPLES_PER_MS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_delay_ms      (r_delay_ms),
        .i_frame_samples (r_frame_samples),
        .i_rearm         (i_cfg_we),
        .i_q_valid       (q_valid),
        .i_q_op          (q_op),
        .o_q_pop         (q_pop),
        .o_init_busy     (init_busy),
        .o_out           (o_out)
    );
endmodule

[tb/sv/tb_rrdl_checker.sv]
// Checker for the resampling reference delay line: predicts fetch results
// from input beats and compares output beats. Depends on rrdl_pkg and the channel interfaces.
`timescale 1ns / 1ps
module tb_rrdl_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [10:0] i_cfg_data,
    rrdl_in_if          i_in,
    rrdl_out_if         i_out,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int DEPTH = rrdl_pkg::RING_DEPTH_DEF;
    localparam int SPM   = rrdl_pkg::SPM_DEF;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               primed;
    } t_fetch_res;

    logic [15:0]  ring [DEPTH];
    logic [31:0]  wr_count;
    logic         is_primed;
    int           h1, h2, last_y;
    int unsigned  phase;
    logic         pushed;
    logic [9:0]   dly_ms;
    logic [10:0]  frm;
    t_fetch_res   fetch_q[$];

    function automatic int unsigned frame_eff();
        if (frm == 0) return 1;
        if (frm > rrdl_pkg::FRAME_MAX) return rrdl_pkg::FRAME_MAX;
        return frm;
    endfunction

    function automatic int unsigned delay_eff();
        int unsigned f, d;
        f = frame_eff();
        d = dly_ms * SPM;
        if (d + f >= DEPTH) d = DEPTH - f - 1;
        return d;
    endfunction

    task automatic store_sample(input int s);
        ring[wr_count % DEPTH] = s[15:0];
        wr_count = wr_count + 1;
        if (!is_primed && wr_count >= delay_eff() + frame_eff()) is_primed = 1'b1;
    endtask

    task automatic apply_beat(input rrdl_pkg::t_cmd c, input logic signed [15:0] x,
                              input logic [15:0] gap, input logic [15:0] blk,
                              input logic [9:0] off);
        int sum, y, s;
        int unsigned n, f;
        logic [31:0] start;
        t_fetch_res r;
        case (c)
            rrdl_pkg::CMD_PUSH: begin
                sum = h2 + 2 * h1 + int'(x);
                y = ((sum + 131072) >>> 2) - 32768;
                h2 = h1;
                h1 = x;
                while (phase < 2) begin
                    s = (phase == 0) ? last_y : (last_y + y) / 2;
                    store_sample(s);
                    phase += 3;
                end
                phase -= 2;
                last_y = y;
                pushed = 1'b1;
            end
            rrdl_pkg::CMD_GAP: begin
                if (pushed && int'(gap) > int'(blk) + rrdl_pkg::GAP_SLACK_MS) begin
                    n = (int'(gap) - int'(blk)) * SPM;
                    if (n > DEPTH) n = DEPTH;
                    repeat (n) store_sample(0);
                end
            end
            rrdl_pkg::CMD_FLUSH: begin
                foreach (ring[i]) ring[i] = '0;
                phase = 0; last_y = 0; h1 = 0; h2 = 0;
                pushed = 1'b0;
            end
            default: begin
                f = frame_eff();
                r.sample = '0;
                if (is_primed && off < f) begin
                    start = wr_count - delay_eff() - f;
                    r.sample = ring[(start + off) % DEPTH];
                end
                r.primed = is_primed;
                fetch_q.push_back(r);
            end
        endcase
    endtask

    assign o_pending = fetch_q.size();

    always @(posedge i_clk) begin
        t_fetch_res e;
        if (!i_rst_n) begin
            foreach (ring[i]) ring[i] = '0;
            wr_count = 0; is_primed = 0; h1 = 0; h2 = 0; last_y = 0;
            phase = 0; pushed = 0; dly_ms = rrdl_pkg::DELAY_RST; frm = rrdl_pkg::FRAME_RST;
            fetch_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (fetch_q.size() == 0) begin
                    $error("unexpected result beat");
                    o_fail_count++;
                end else begin
                    e = fetch_q.pop_front();
                    if (i_out.ref_sample !== e.sample) begin
                        $error("ref_sample expected %0d actual %0d", e.sample, i_out.ref_sample);
                        o_fail_count++;
                    end
                    if (i_out.primed !== e.primed) begin
                        $error("primed expected %0d actual %0d", e.primed, i_out.primed);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == rrdl_pkg::CFG_IDX_DELAY) dly_ms = i_cfg_data[9:0];
                else frm = i_cfg_data;
                is_primed = 1'b0;
            end
            if (i_in.valid && i_in.ready)
                apply_beat(rrdl_pkg::t_cmd'(i_in.cmd), i_in.spk_sample, i_in.gap_ms,
                           i_in.block_ms, i_in.frame_offset);
        end
    end
endmodule

[tb/sv/tb_top.sv]
// Testbench top for resampling_reference_delay_line: drives commands and
// configuration, randomizes idling, gives the verdict. Depends on tb_rrdl_checker.
`timescale 1ns / 1ps
module tb_top;
    localparam int WD_LIMIT  = 400000;
    localparam int IDLE_WAIT = 3 * (rrdl_pkg::RING_DEPTH_DEF + 2) + 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [10:0] cfg_data = '0;
    int          fail_count, pending;
    int          idle_cycles = 0;
    bit          no_idle = 0;

    rrdl_in_if  in_ch ();
    rrdl_out_if out_ch ();

    resampling_reference_delay_line u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    tb_rrdl_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_in(in_ch), .i_out(out_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 0; in_ch.cmd = 0; in_ch.spk_sample = 0;
        in_ch.gap_ms = 0; in_ch.block_ms = 0; in_ch.frame_offset = 0;
        out_ch.ready = 0;
    end

    always @(posedge i_clk)
        out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 21);

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic send_beat(input rrdl_pkg::t_cmd c, input logic [15:0] smp,
                             input logic [15:0] gap, input logic [15:0] blk,
                             input logic [9:0] off);
        while (!no_idle && $urandom_range(99) < 21) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= c;
        in_ch.spk_sample <= smp;
        in_ch.gap_ms <= gap;
        in_ch.block_ms <= blk;
        in_ch.frame_offset <= off;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [10:0] val);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_beat(input int unsigned frm_hint);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            send_beat(rrdl_pkg::CMD_PUSH, 16'($urandom), 0, 0, 0);
        else if (r < 85)
            send_beat(rrdl_pkg::CMD_FETCH, 0, 16'($urandom), 16'($urandom),
                      ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(frm_hint)));
        else if (r < 97)
            send_beat(rrdl_pkg::CMD_GAP, 16'($urandom), 16'($urandom_range(40)),
                      16'($urandom_range(15)), 10'($urandom));
        else if (r < 99)
            send_beat(rrdl_pkg::CMD_GAP, 16'($urandom), 16'($urandom), 16'($urandom),
                      10'($urandom));
        else
            send_beat(rrdl_pkg::CMD_FLUSH, 16'($urandom), 16'($urandom), 16'($urandom),
                      10'($urandom));
    endtask

    initial begin
        int unsigned frm;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed
        send_beat(rrdl_pkg::CMD_GAP, 0, 16'hFFFF, 0, 0);
        send_beat(rrdl_pkg::CMD_FETCH, 0, 0, 0, 0);
        send_beat(rrdl_pkg::CMD_PUSH, 16'h7FFF, 0, 0, 0);
        send_beat(rrdl_pkg::CMD_PUSH, 16'h8000, 0, 0, 0);
        send_beat(rrdl_pkg::CMD_PUSH, 16'h8000, 0, 0, 0);
        send_beat(rrdl_pkg::CMD_PUSH, 16'h7FFF, 0, 0, 0);
        send_beat(rrdl_pkg::CMD_GAP, 0, 16'd30, 16'd10, 0);
        send_beat(rrdl_pkg::CMD_GAP, 0, 16'd31, 16'd10, 0);
        send_beat(rrdl_pkg::CMD_GAP, 0, 16'hFFFF, 16'hFFFF, 0);
        send_beat(rrdl_pkg::CMD_GAP, 0, 16'hFFFF, 16'd0, 0);
        send_beat(rrdl_pkg::CMD_FETCH, 0, 0, 0, 10'd0);
        send_beat(rrdl_pkg::CMD_FETCH, 0, 0, 0, 10'd511);
        send_beat(rrdl_pkg::CMD_FETCH, 0, 0, 0, 10'd512);
        send_beat(rrdl_pkg::CMD_FETCH, 0, 0, 0, 10'h3FF);
        send_beat(rrdl_pkg::CMD_FLUSH, 0, 0, 0, 0);
        send_beat(rrdl_pkg::CMD_GAP, 0, 16'd100, 16'd0, 0);
        send_beat(rrdl_pkg::CMD_FETCH, 0, 0, 0, 10'd3);
        write_reg(rrdl_pkg::CFG_IDX_FRAME, 11'd0);
        write_reg(rrdl_pkg::CFG_IDX_DELAY, 11'd0);
        send_beat(rrdl_pkg::CMD_PUSH, 16'h1234, 0, 0, 0);
        send_beat(rrdl_pkg::CMD_PUSH, 16'hFFFF, 0, 0, 0);
        send_beat(rrdl_pkg::CMD_FETCH, 0, 0, 0, 10'd0);
        send_beat(rrdl_pkg::CMD_FETCH, 0, 0, 0, 10'd1);
        // random phases with varied settings
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin
                    write_reg(rrdl_pkg::CFG_IDX_FRAME, 11'h7FF);
                    write_reg(rrdl_pkg::CFG_IDX_DELAY, 11'h3FF);
                end
                1: begin
                    write_reg(rrdl_pkg::CFG_IDX_FRAME, 11'd1);
                    write_reg(rrdl_pkg::CFG_IDX_DELAY, 11'd0);
                end
                2: begin
                    write_reg(rrdl_pkg::CFG_IDX_FRAME, 11'd1024);
                    write_reg(rrdl_pkg::CFG_IDX_DELAY, 11'd1);
                end
                3: begin
                    write_reg(rrdl_pkg::CFG_IDX_FRAME, 11'd1025);
                    write_reg(rrdl_pkg::CFG_IDX_DELAY, 11'd2);
                end
                default: begin
                    write_reg(rrdl_pkg::CFG_IDX_FRAME, 11'($urandom_range(1, 64)));
                    write_reg(rrdl_pkg::CFG_IDX_DELAY, 11'($urandom_range(3)));
                end
            endcase
            frm = (ph == 0 || ph == 2 || ph == 3) ? 1023 : 63;
            no_idle = (ph == 5);
            repeat (50) random_beat(frm);
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
